// ===== hdl/tdp_pkg.sv =====
// Package for the trial division prime test.
// Holds the default value width, the sequencer state type and the wheel constants.
// Depends on nothing.
`default_nettype none

package tdp_pkg;

  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  localparam int unsigned DIVISOR_THREE = 3;
  localparam int unsigned DIVISOR_FIRST = 5;
  localparam int unsigned PAIR_OFFSET   = 2;
  localparam int unsigned WHEEL_STEP    = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD3,
    ST_DIV_LO,
    ST_DIV_HI
  } tdp_state_e;

endpackage

`default_nettype wire

// ===== hdl/trial_division_prime_test.sv =====
// Top level of the trial division prime test: sequencer over one shared divider.
// Depends on tdp_pkg and tdp_divider.
`default_nettype none

// An item is taken when start is high and busy is low; its answer is on is_prime_o while
// done_o is high for exactly one cycle, and the receiver cannot stall it. Negative values, 0,
// 1, 2, 3 and even values are answered from the accept decision through the done and result
// registers, without the divider. Every other value goes through one shared restoring
// divider: one division by 3, then two divisions (by d and d + 2) per wheel step d = 5, 11,
// 17 and so on while d <= n / d. The divider loop sets the rate; busy stays high for the
// whole test of such a value.
module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] candidate_i,
  output logic                               busy,
  output logic                               done_o,
  output logic                               is_prime_o
);

  tdp_pkg::tdp_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic                   done_q, done_d;
  logic                   prime_q, prime_d;

  logic                   accept;
  logic                   below_two;
  logic                   two_or_three;
  logic                   quick_answer;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_divisor;
  logic                   div_busy;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;
  logic                   rem_zero;
  logic                   past_root;

  assign accept       = start && (state_q == tdp_pkg::ST_IDLE);
  assign below_two    = candidate_i[VALUE_WIDTH-1] || (candidate_i[VALUE_WIDTH-1:1] == '0);
  assign two_or_three = !candidate_i[VALUE_WIDTH-1] &&
                        (candidate_i[VALUE_WIDTH-1:1] == (VALUE_WIDTH-1)'(1));
  assign quick_answer = below_two || two_or_three || !candidate_i[0];
  assign rem_zero     = (div_rem == '0);
  assign past_root    = (d_q > div_quo);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdp_pkg::ST_IDLE: begin
        if (accept && !quick_answer) state_d = tdp_pkg::ST_MOD3;
      end
      tdp_pkg::ST_MOD3: begin
        if (div_done) state_d = rem_zero ? tdp_pkg::ST_IDLE : tdp_pkg::ST_DIV_LO;
      end
      tdp_pkg::ST_DIV_LO: begin
        if (div_done) state_d = (past_root || rem_zero) ? tdp_pkg::ST_IDLE : tdp_pkg::ST_DIV_HI;
      end
      tdp_pkg::ST_DIV_HI: begin
        if (div_done) state_d = rem_zero ? tdp_pkg::ST_IDLE : tdp_pkg::ST_DIV_LO;
      end
      default: state_d = tdp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    n_d          = n_q;
    d_d          = d_q;
    done_d       = 1'b0;
    prime_d      = prime_q;
    div_start    = 1'b0;
    div_dividend = n_q;
    div_divisor  = VALUE_WIDTH'(tdp_pkg::DIVISOR_THREE);
    unique case (state_q)
      tdp_pkg::ST_IDLE: begin
        div_dividend = candidate_i;
        if (accept) begin
          n_d = candidate_i;
          priority if (below_two) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
          end else if (two_or_three) begin
            done_d  = 1'b1;
            prime_d = 1'b1;
          end else if (!candidate_i[0]) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      tdp_pkg::ST_MOD3: begin
        div_divisor = VALUE_WIDTH'(tdp_pkg::DIVISOR_FIRST);
        if (div_done) begin
          if (rem_zero) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
          end else begin
            d_d       = VALUE_WIDTH'(tdp_pkg::DIVISOR_FIRST);
            div_start = 1'b1;
          end
        end
      end
      tdp_pkg::ST_DIV_LO: begin
        div_divisor = d_q + VALUE_WIDTH'(tdp_pkg::PAIR_OFFSET);
        if (div_done) begin
          priority if (past_root) begin
            done_d  = 1'b1;
            prime_d = 1'b1;
          end else if (rem_zero) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      tdp_pkg::ST_DIV_HI: begin
        div_divisor = d_q + VALUE_WIDTH'(tdp_pkg::WHEEL_STEP);
        if (div_done) begin
          if (rem_zero) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
          end else begin
            d_d       = d_q + VALUE_WIDTH'(tdp_pkg::WHEEL_STEP);
            div_start = 1'b1;
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdp_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    prime_q <= prime_d;
  end

  tdp_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign busy       = (state_q != tdp_pkg::ST_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

  a_idle_divider_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !div_busy && !div_done)
    else $error("divider active while sequencer idle");

  a_done_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start))
    else $error("result beat without an accepted item");

  a_divisor_odd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdp_pkg::ST_DIV_LO || state_q == tdp_pkg::ST_DIV_HI) |-> d_q[0])
    else $error("wheel divisor is even");

  a_busy_runs_divider : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> div_busy || div_done)
    else $error("sequencer busy with divider stopped");

endmodule

`default_nettype wire

// ===== hdl/tdp_divider.sv =====
// Shared restoring divider for the trial division prime test.
// One quotient bit per cycle; depends on tdp_pkg for the default width.
`default_nettype none

module tdp_divider #(
  parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      quotient_o,
  output logic [VALUE_WIDTH-1:0]      remainder_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH+1:0] diff;

  assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(VALUE_WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[VALUE_WIDTH+1]) begin
        rem_d = diff[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0) && (cnt_q <= CntWidth'(VALUE_WIDTH)))
    else $error("divider count out of range while busy");

  a_done_ends_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

  a_done_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
